/* design/rate_limit_keyword_matcher_macros.svh */
// assertion macros for the rate limit keyword matcher
// expects clk and rst_n to be visible where a macro is used
`ifndef RATE_LIMIT_KEYWORD_MATCHER_MACROS_SVH
`define RATE_LIMIT_KEYWORD_MATCHER_MACROS_SVH

// same-cycle implication
`define RLKM_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("rlkm assertion failed");

// next-cycle implication
`define RLKM_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("rlkm assertion failed");

`endif

/* design/rlkm_pkg.sv */
// shared types, keyword constants and lookup functions
// used by rlkm_cell and rate_limit_keyword_matcher
`default_nettype none

package rlkm_pkg;

  localparam int KW_COUNT  = 10;
  localparam int WIN_DEPTH = 16;
  localparam int KW_MAXLEN = 17;
  localparam int POS_W     = 13;

  localparam logic [POS_W-1:0] POS_MAX         = '1;
  localparam logic [POS_W-1:0] SCAN_LIMIT_RST  = 13'd512;

  // keyword indexes with a meaning of their own in the verdict
  localparam int KW_429 = 6;
  localparam logic [KW_COUNT-1:0] KW_PHRASE_MASK = 10'h03F;
  localparam logic [KW_COUNT-1:0] KW_COMPANION_MASK = 10'h380;

  typedef logic [KW_MAXLEN*8-1:0] kw_str_t;
  typedef logic [KW_COUNT-1:0][7:0] kw_bytes_t;
  typedef logic [KW_COUNT-1:0] kw_vec_t;

  // right-aligned: the last character sits in the low byte
  localparam kw_str_t KW_STR [KW_COUNT] = '{
    kw_str_t'("ratelimited"),
    kw_str_t'("rate limited"),
    kw_str_t'("rate\137limit"),
    kw_str_t'("too many requests"),
    kw_str_t'("quota exceeded"),
    kw_str_t'("throttle"),
    kw_str_t'("429"),
    kw_str_t'("rate"),
    kw_str_t'("limit"),
    kw_str_t'("too many")
  };

  localparam int KW_LEN [KW_COUNT] = '{11, 12, 10, 17, 14, 8, 3, 4, 5, 8};

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

  // expected byte of every keyword at distance d from its last character
  function automatic kw_bytes_t exp_bytes(input int d);
    kw_bytes_t b;
    for (int k = 0; k < KW_COUNT; k++) begin
      b[k] = KW_STR[k][d*8 +: 8];
    end
    return b;
  endfunction

  // which keywords reach back as far as distance d
  function automatic kw_vec_t exp_care(input int d);
    kw_vec_t c;
    for (int k = 0; k < KW_COUNT; k++) begin
      c[k] = (d < KW_LEN[k]);
    end
    return c;
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
  endfunction

endpackage

`default_nettype wire

/* design/rlkm_cell.sv */
// one window cell: holds a past byte and compares it against every keyword
// depends on rlkm_pkg
`default_nettype none

module rlkm_cell
  import rlkm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire logic [7:0] byte_in,
  input  wire kw_bytes_t exp_byte,
  input  wire kw_vec_t   exp_need,
  output logic [7:0]     byte_out,
  output kw_vec_t        match
);

  logic [7:0] byte_r, byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clr) begin
      byte_nxt = '0;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // keywords that do not reach this far pass as matched
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      match[k] = !exp_need[k] || (byte_r == exp_byte[k]);
    end
  end

  assign byte_out = byte_r;

endmodule

`default_nettype wire

/* design/rate_limit_keyword_matcher.sv */
// top level of the rate limit keyword matcher: control, flags, config port
// depends on rlkm_pkg, rlkm_cell and rate_limit_keyword_matcher_macros.svh
//
// usage:
//   input channel (in_valid, in_stall, in_char_byte, in_last_byte) takes one
//   message byte per beat; in_last_byte marks the final beat of a message.
//   result channel (out_valid, out_stall, out_rate_limited) gives one beat
//   per message, in the cycle after its last byte is accepted.
//   throughput is one byte per cycle while in_stall is low: all sixteen window
//   cells compare in parallel against the ten keywords in the same cycle the
//   byte arrives. while a result waits under out_stall, non-final bytes are
//   still taken; only a final byte is held off until the result register
//   frees up. scan_limit sits at byte address 0 of the apb port (psel, penable,
//   pwrite, paddr, pwdata, prdata, pready), reset value 512; write it only
//   while the block is idle. bytes at positions at or past scan_limit are
//   ignored, and the position counter saturates at 8191.
//   reset (rst_n low, synchronous) clears the window, flags, position and
//   out_valid; out_rate_limited is not reset. there is no clearing pass.
`default_nettype none
`include "rate_limit_keyword_matcher_macros.svh"

module rate_limit_keyword_matcher
  import rlkm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_rate_limited,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic ADDR_SCAN_LIMIT = 1'b0;

  logic [POS_W-1:0] scan_limit_r, scan_limit_nxt;
  logic [POS_W-1:0] position_r, position_nxt;
  kw_vec_t          seen_r, seen_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_rl_r, out_rl_nxt;

  logic      in_acc, counted, hit;
  logic [7:0] cur;
  kw_vec_t   cur_match, hits, seen_all;
  cell_ctl_t ctl;

  logic [7:0] chain [WIN_DEPTH+1];
  kw_vec_t    cell_match [WIN_DEPTH];

  // ---------------- config port ----------------
  assign pready = 1'b1;

  always_comb begin
    scan_limit_nxt = scan_limit_r;
    if (psel && penable && pwrite && pready && paddr[2] == ADDR_SCAN_LIMIT) begin
      scan_limit_nxt = pwdata[POS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ADDR_SCAN_LIMIT) ?
                  {{(32-POS_W){1'b0}}, scan_limit_r} : 32'd0;

  // ---------------- handshake ----------------
  // only a final byte needs the result register
  assign in_stall = out_valid_r && out_stall && in_last_byte;
  assign in_acc   = in_valid && !in_stall;

  assign cur     = fold_lower(in_char_byte);
  assign counted = (position_r < scan_limit_r);

  assign ctl.shift = in_acc && counted && !in_last_byte;
  assign ctl.clr   = in_acc && in_last_byte;

  // ---------------- window cells ----------------
  assign chain[0] = cur;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    rlkm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (chain[i]),
      .exp_byte (exp_bytes(i + 1)),
      .exp_need (exp_care(i + 1)),
      .byte_out (chain[i+1]),
      .match    (cell_match[i])
    );
  end

  // last character of each keyword against the incoming byte
  always_comb begin
    kw_bytes_t last_chr;
    last_chr = exp_bytes(0);
    for (int k = 0; k < KW_COUNT; k++) begin
      cur_match[k] = (cur == last_chr[k]);
    end
  end

  always_comb begin
    hits = cur_match;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      hits = hits & cell_match[i];
    end
  end

  // ---------------- flags, position, verdict ----------------
  assign seen_all = seen_r | (counted ? hits : '0);
  assign hit = (|(seen_all & KW_PHRASE_MASK)) ||
               (seen_all[KW_429] && (|(seen_all & KW_COMPANION_MASK)));

  always_comb begin
    seen_nxt     = seen_r;
    position_nxt = position_r;
    if (in_acc) begin
      if (in_last_byte) begin
        seen_nxt     = '0;
        position_nxt = '0;
      end else begin
        seen_nxt = seen_all;
        if (position_r != POS_MAX) begin
          position_nxt = position_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rl_nxt    = out_rl_r;
    if (in_acc && in_last_byte) begin
      out_valid_nxt = 1'b1;
      out_rl_nxt    = hit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= SCAN_LIMIT_RST;
      position_r   <= '0;
      seen_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      scan_limit_r <= scan_limit_nxt;
      position_r   <= position_nxt;
      seen_r       <= seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rl_r <= out_rl_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_rate_limited = out_rl_r;

  // ---------------- assertions ----------------
  `RLKM_ASSERT_NEXT(a_clear_on_last, in_acc && in_last_byte,
                    position_r == '0 && seen_r == '0)
  `RLKM_ASSERT_NEXT(a_flags_hold_past_limit, in_acc && !in_last_byte && !counted,
                    $stable(seen_r))
  `RLKM_ASSERT_NEXT(a_position_step, in_acc && !in_last_byte && position_r != POS_MAX,
                    position_r == $past(position_r) + 1'b1)
  `RLKM_ASSERT_IMP(a_result_from_last, $rose(out_valid_r),
                   $past(in_acc && in_last_byte))

endmodule

`default_nettype wire

/* test/rate_limit_keyword_matcher_tb.sv */
// testbench for rate_limit_keyword_matcher: directed byte table, then random
// messages checked beat by beat against a keyword scanner kept in this file
// depends on the rate_limit_keyword_matcher rtl
`timescale 1ns / 100ps

module rate_limit_keyword_matcher_tb;

  localparam int NUM_KW = 10;
  localparam int HIST = 16;
  localparam logic [12:0] POS_TOP = 13'h1FFF;
  localparam logic [12:0] LIMIT_AT_RESET = 13'd512;
  localparam logic [2:0] ADDR_SCAN_LIMIT = 3'd0;
  localparam int IDX_429 = 6;
  localparam logic [NUM_KW-1:0] PHRASE_MASK = 10'h03F;
  localparam logic [NUM_KW-1:0] COMPANION_MASK = 10'h380;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 9;
  localparam int BYTES_PER_PHASE = 80;
  localparam int PRESSURE_PHASE = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_PROBES = 25;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic       want;
  } probe_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_rate_limited;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  string kw_text [NUM_KW] = '{"ratelimited", "rate limited", "rate\137limit",
                              "too many requests", "quota exceeded", "throttle",
                              "429", "rate", "limit", "too many"};

  int scan_limits [NUM_PHASES] = '{4096, 1, 12, 0, 25, 512, 7, 60, 4096};

  // directed bytes: byte extremes, case folding edges, a phrase, 429 + companion
  probe_row_t probe_rows [NUM_PROBES] = '{
    '{8'h00, 1'b1, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b1, 1'b0},
    '{"@",   1'b1, 1'b1, 1'b0}, '{"[",   1'b1, 1'b1, 1'b0},
    '{"T", 1'b0, 1'b0, 1'b0}, '{"h", 1'b0, 1'b0, 1'b0}, '{"R", 1'b0, 1'b0, 1'b0},
    '{"o", 1'b0, 1'b0, 1'b0}, '{"t", 1'b0, 1'b0, 1'b0}, '{"T", 1'b0, 1'b0, 1'b0},
    '{"l", 1'b0, 1'b0, 1'b0}, '{"E", 1'b1, 1'b1, 1'b1},
    '{"4", 1'b0, 1'b0, 1'b0}, '{"2", 1'b0, 1'b0, 1'b0}, '{"9", 1'b0, 1'b0, 1'b0},
    '{" ", 1'b0, 1'b0, 1'b0}, '{"L", 1'b0, 1'b0, 1'b0}, '{"i", 1'b0, 1'b0, 1'b0},
    '{"M", 1'b0, 1'b0, 1'b0}, '{"i", 1'b0, 1'b0, 1'b0}, '{"T", 1'b1, 1'b1, 1'b1},
    '{"R", 1'b0, 1'b0, 1'b0}, '{"a", 1'b0, 1'b0, 1'b0}, '{"T", 1'b0, 1'b0, 1'b0},
    '{"e", 1'b1, 1'b0, 1'b0}
  };

  // scanner state
  logic [7:0]        hist_q [HIST];
  logic [NUM_KW-1:0] seen_kw;
  logic [12:0]       pos_count;
  logic [12:0]       limit_model;

  logic       verdict_q [$];
  logic [7:0] msg_buf [$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         hold_left = 0;
  bit         hold_req = 0;
  logic       rx_want;

  rate_limit_keyword_matcher uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rate_limited (out_rate_limited),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_message();
    for (int j = 0; j < HIST; j++) begin
      hist_q[j] = 8'h00;
    end
    seen_kw = '0;
    pos_count = '0;
  endfunction

  // feeds one byte to the scanner, returns the verdict as of this byte
  function automatic logic scan_byte(input logic [7:0] raw, input logic last);
    logic [7:0] cur;
    logic       match;
    logic       verdict;
    int         n;
    cur = (raw >= 8'h41 && raw <= 8'h5A) ? raw + 8'h20 : raw;
    if (pos_count < limit_model) begin
      for (int k = 0; k < NUM_KW; k++) begin
        n = kw_text[k].len();
        match = (kw_text[k][n-1] == cur);
        for (int i = 1; i < n; i++) begin
          if (kw_text[k][n-1-i] != hist_q[i-1]) match = 1'b0;
        end
        if (match) seen_kw[k] = 1'b1;
      end
      for (int j = HIST - 1; j > 0; j--) begin
        hist_q[j] = hist_q[j-1];
      end
      hist_q[0] = cur;
    end
    if (pos_count != POS_TOP) pos_count = pos_count + 13'd1;
    verdict = (|(seen_kw & PHRASE_MASK)) ||
              (seen_kw[IDX_429] && |(seen_kw & COMPANION_MASK));
    if (last) clear_message();
    return verdict;
  endfunction

  task automatic log_failure(input string what, input logic want, input logic got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR cycle %0d: %s, expected %b, got %b", cycle_count, what, want, got);
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last, input logic typed,
                          input logic want);
    logic verdict;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict = scan_byte(b, last);
    if (last) verdict_q.push_back(typed ? want : verdict);
  endtask

  task automatic write_scan_limit(input logic [31:0] value);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SCAN_LIMIT;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_model = value[12:0];
  endtask

  task automatic push_char(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'h20;
    msg_buf.push_back(c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i]);
    end
  endtask

  // mostly keyword-rich text with random case, sometimes raw noise
  task automatic build_message();
    int    k;
    string s;
    msg_buf.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 20)) msg_buf.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(20, 70)) push_char(8'h61 + 8'($urandom_range(25)));
      end
      repeat ($urandom_range(1, 6)) begin
        k = $urandom_range(NUM_KW - 1);
        s = kw_text[k];
        case ($urandom_range(9)) inside
          [0:3]: push_text(s);
          4: push_text(s.substr(0, $urandom_range(s.len() - 2)));
          5: push_char($urandom_range(1) ? 8'h20 : 8'h5F);
          6: repeat ($urandom_range(1, 6)) push_char(8'h61 + 8'($urandom_range(25)));
          7: repeat ($urandom_range(1, 3)) msg_buf.push_back(8'($urandom_range(255)));
          8: push_text("429");
          default: begin
            // keyword with one byte knocked out
            s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
            push_text(s);
          end
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check each beat, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        log_failure("result beat with no message pending", 1'bx, out_rate_limited);
      end else begin
        rx_want = verdict_q.pop_front();
        if (out_rate_limited !== rx_want) begin
          log_failure("rate_limited mismatch", rx_want, out_rate_limited);
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    int sent;
    clear_message();
    limit_model = LIMIT_AT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[r]) begin
      put_byte(probe_rows[r].ch, probe_rows[r].last, probe_rows[r].typed,
               probe_rows[r].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_scan_limit(scan_limits[p]);
      if (p < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 74;
      end else if (p < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long receiver hold so final bytes back up behind a waiting result
      if (p == PRESSURE_PHASE) hold_req = 1;
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        build_message();
        foreach (msg_buf[i]) begin
          put_byte(msg_buf[i], i == msg_buf.size() - 1, 1'b0, 1'b0);
        end
        sent += msg_buf.size();
      end
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
